[hw/rtl/ntri_pkg.sv]
// shared constants and codes of the neighbour table and rank indicator
package ntri_pkg;

	localparam int SLOTS  = 10;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int DIV_W  = 2 * CNT_W;
	localparam int QS_W   = (CNT_W > 2) ? $clog2(CNT_W) : 1;

	localparam int KIND_W  = 2;
	localparam int ID_W    = 7;
	localparam int DIST_W  = 24;
	localparam int STAMP_W = 32;
	localparam int FLD_W   = 4;
	localparam int IND_W   = 2;

	localparam logic [KIND_W-1:0] KIND_REPORT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RANK   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

	localparam logic [IND_W-1:0] IND_OFF   = 2'd0;
	localparam logic [IND_W-1:0] IND_GREEN = 2'd1;
	localparam logic [IND_W-1:0] IND_RED   = 2'd2;

endpackage

[hw/rtl/ntri_if.sv]
// handshake channels of the neighbour table and rank indicator
interface ntri_item_if
	import ntri_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [ID_W-1:0]    neighbor_id;
	logic [DIST_W-1:0]  reported_distance;
	logic [DIST_W-1:0]  own_distance;
	logic [STAMP_W-1:0] now;

	modport source (output valid, kind, neighbor_id, reported_distance, own_distance, now,
		input ready);
	modport sink (input valid, kind, neighbor_id, reported_distance, own_distance, now,
		output ready);
endinterface

interface ntri_result_if
	import ntri_pkg::*;
	;
	logic             valid;
	logic             ready;
	logic [FLD_W-1:0] slot_written;
	logic             new_entry;
	logic [FLD_W-1:0] valid_count;
	logic [FLD_W-1:0] closer_count;
	logic [FLD_W-1:0] level;
	logic [IND_W-1:0] indicator;

	modport source (output valid, slot_written, new_entry, valid_count, closer_count, level,
		indicator, input ready);
	modport sink (input valid, slot_written, new_entry, valid_count, closer_count, level,
		indicator, output ready);
endinterface

interface ntri_cfg_if;
	logic valid;
	logic ready;
	logic enabled;

	modport source (output valid, enabled, input ready);
	modport sink (input valid, enabled, output ready);
endinterface

[hw/rtl/neighbor_table_rank_indicator.sv]
// neighbour table, rank level and indicator stepping with one shared comparator
// report and rank query: a scan over every slot, then the finish state, one entry scanned per cycle
// enabled rank query with valid entries: a restoring division follows the finish state
// display tick and unused kind: straight to the done state; every kind loads its result
// as the sequencer returns to idle, a waiting result holds the sequencer until it is taken
// arst_n clears control state, valid bits, level, step and the enable register
module neighbor_table_rank_indicator
	import ntri_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	ntri_item_if.sink     item,
	ntri_cfg_if.sink      cfg,
	ntri_result_if.source result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_FIN  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;

	logic               ent_valid_q [SLOTS];
	logic [ID_W-1:0]    ent_id_q    [SLOTS];
	logic [DIST_W-1:0]  ent_dist_q  [SLOTS];
	logic [STAMP_W-1:0] ent_stamp_q [SLOTS];

	logic               enabled_q;
	logic [CNT_W-1:0]   level_q;
	logic [CNT_W-1:0]   blink_q;

	logic [KIND_W-1:0]  kind_q;
	logic [ID_W-1:0]    id_q;
	logic [DIST_W-1:0]  dist_q;
	logic [DIST_W-1:0]  own_q;
	logic [STAMP_W-1:0] now_q;

	logic [IDX_W-1:0]   idx_q;
	logic               found_q;
	logic [IDX_W-1:0]   match_idx_q;
	logic [IDX_W-1:0]   old_idx_q;
	logic [STAMP_W-1:0] old_stamp_q;
	logic [CNT_W-1:0]   vcnt_q;
	logic [CNT_W-1:0]   ccnt_q;
	logic [DIV_W-1:0]   rem_q;
	logic [CNT_W-1:0]   quo_q;
	logic [QS_W-1:0]    dstep_q;

	logic               res_valid_q;
	logic [FLD_W-1:0]   res_slot_q;
	logic               res_new_q;
	logic [FLD_W-1:0]   res_vcnt_q;
	logic [FLD_W-1:0]   res_ccnt_q;
	logic [FLD_W-1:0]   res_level_q;
	logic [IND_W-1:0]   res_ind_q;

	logic               rd_valid;
	logic [STAMP_W-1:0] rd_stamp;
	logic [STAMP_W-1:0] cmp_a;
	logic [STAMP_W-1:0] cmp_b;
	logic               cmp_lt;
	logic [DIV_W-1:0]   dvs_sh;
	logic               scan_last;
	logic               out_free;
	logic [IDX_W-1:0]   target;
	logic [CNT_W-1:0]   blink_nxt;
	logic [CNT_W-1:0]   level_nxt;

	assign item.ready = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;

	assign rd_valid  = ent_valid_q[idx_q];
	assign rd_stamp  = rd_valid ? ent_stamp_q[idx_q] : '0;
	assign dvs_sh    = DIV_W'(vcnt_q) << dstep_q;
	assign scan_last = (idx_q == IDX_W'(SLOTS - 1));
	assign out_free  = !res_valid_q || result.ready;
	assign target    = found_q ? match_idx_q : old_idx_q;
	assign blink_nxt = (blink_q == CNT_W'(SLOTS - 1)) ? '0 : blink_q + 1'b1;
	assign level_nxt = (vcnt_q == '0) ? '0 : quo_q;

	// shared comparator: stamps, distances or the trial divisor
	always_comb begin
		cmp_a = rd_stamp;
		cmp_b = old_stamp_q;
		case (state_q)
			ST_SCAN: begin
				if (kind_q == KIND_RANK) begin
					cmp_a = STAMP_W'(ent_dist_q[idx_q]);
					cmp_b = STAMP_W'(own_q);
				end
			end
			ST_DIV: begin
				cmp_a = STAMP_W'(rem_q);
				cmp_b = STAMP_W'(dvs_sh);
			end
			default: begin
			end
		endcase
	end

	assign cmp_lt = (cmp_a < cmp_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (cfg.valid) begin
			enabled_q <= cfg.enabled;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			kind_q <= item.kind;
			id_q   <= item.neighbor_id;
			dist_q <= item.reported_distance;
			own_q  <= item.own_distance;
			now_q  <= item.now;
		end
	end

	// table payload, written on report completion
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free && kind_q == KIND_REPORT) begin
			ent_id_q[target]    <= id_q;
			ent_dist_q[target]  <= dist_q;
			ent_stamp_q[target] <= now_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				ent_valid_q[i] <= 1'b0;
			end
		end else if (state_q == ST_DONE && out_free && kind_q == KIND_REPORT) begin
			ent_valid_q[target] <= 1'b1;
		end
	end

	// sequencer and scan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			found_q     <= 1'b0;
			match_idx_q <= '0;
			old_idx_q   <= '0;
			old_stamp_q <= '0;
			vcnt_q      <= '0;
			ccnt_q      <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			dstep_q     <= '0;
			level_q     <= '0;
			blink_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						vcnt_q  <= '0;
						ccnt_q  <= '0;
						if (item.kind == KIND_REPORT || item.kind == KIND_RANK) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (kind_q == KIND_REPORT) begin
						if (rd_valid && ent_id_q[idx_q] == id_q && !found_q) begin
							found_q     <= 1'b1;
							match_idx_q <= idx_q;
						end
						if (idx_q == '0 || cmp_lt) begin
							old_idx_q   <= idx_q;
							old_stamp_q <= rd_stamp;
						end
					end else if (rd_valid) begin
						vcnt_q <= vcnt_q + 1'b1;
						if (cmp_lt) begin
							ccnt_q <= ccnt_q + 1'b1;
						end
					end
					if (scan_last) begin
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FIN: begin
					quo_q   <= '0;
					dstep_q <= QS_W'(CNT_W - 1);
					rem_q   <= DIV_W'(ccnt_q * DIV_W'(SLOTS));
					if (kind_q == KIND_RANK && enabled_q && vcnt_q != '0) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (!cmp_lt) begin
						rem_q          <= rem_q - dvs_sh;
						quo_q[dstep_q] <= 1'b1;
					end
					if (dstep_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						dstep_q <= dstep_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (kind_q == KIND_RANK && enabled_q) begin
							level_q <= level_nxt;
						end
						if (kind_q == KIND_TICK && enabled_q) begin
							blink_q <= blink_nxt;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			case (kind_q)
				KIND_REPORT: begin
					res_slot_q  <= FLD_W'(target);
					res_new_q   <= !found_q;
					res_vcnt_q  <= '0;
					res_ccnt_q  <= '0;
					res_level_q <= FLD_W'(level_q);
					res_ind_q   <= IND_OFF;
				end
				KIND_RANK: begin
					res_slot_q  <= '0;
					res_new_q   <= 1'b0;
					res_vcnt_q  <= FLD_W'(vcnt_q);
					res_ccnt_q  <= FLD_W'(ccnt_q);
					res_level_q <= enabled_q ? FLD_W'(level_nxt) : FLD_W'(level_q);
					res_ind_q   <= IND_OFF;
				end
				KIND_TICK: begin
					res_slot_q  <= '0;
					res_new_q   <= 1'b0;
					res_vcnt_q  <= '0;
					res_ccnt_q  <= '0;
					res_level_q <= FLD_W'(level_q);
					if (enabled_q) begin
						res_ind_q <= (blink_nxt >= level_q) ? IND_GREEN : IND_RED;
					end else begin
						res_ind_q <= IND_OFF;
					end
				end
				default: begin
					res_slot_q  <= '0;
					res_new_q   <= 1'b0;
					res_vcnt_q  <= '0;
					res_ccnt_q  <= '0;
					res_level_q <= FLD_W'(level_q);
					res_ind_q   <= IND_OFF;
				end
			endcase
		end
	end

	assign result.valid        = res_valid_q;
	assign result.slot_written = res_slot_q;
	assign result.new_entry    = res_new_q;
	assign result.valid_count  = res_vcnt_q;
	assign result.closer_count = res_ccnt_q;
	assign result.level        = res_level_q;
	assign result.indicator    = res_ind_q;

`ifndef ASSERT_OFF
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> state_q != ST_IDLE)
		else $error("sequencer idle after input transfer");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= CNT_W'(SLOTS))
		else $error("rank level above slot count");

	a_closer_le_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ccnt_q <= vcnt_q)
		else $error("closer count exceeds valid count");

	a_blink_range: assert property (@(posedge clk) disable iff (!arst_n)
		blink_q < CNT_W'(SLOTS))
		else $error("blink step out of range");
`endif

endmodule
